// ===== src/lndet_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lndet_pkg
// Shared constants, types and register codes for the landing detector.
// ----------------------------------------------------------------------------
package lndet_pkg;

    // ring of recent vertical speeds
    localparam int RING_DEPTH = 10;
    localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // running sum of the ring: 32-bit entries, RING_DEPTH of them, plus sign
    localparam int SPEED_W = 32;
    localparam int SUM_W   = SPEED_W + $clog2(RING_DEPTH) + 1;

    // input field widths
    localparam int ALT_W   = 28;
    localparam int TICK_W  = 16;
    localparam int PHASE_W = 32;

    // config register widths
    localparam int LAND_W   = 17;
    localparam int DEB_W    = 8;
    localparam int UNWIND_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [LAND_W-1:0]   LAND_RST   = LAND_W'(1000);
    localparam logic [DEB_W-1:0]    DEB_RST    = DEB_W'(30);
    localparam logic [UNWIND_W-1:0] UNWIND_RST = UNWIND_W'(2000);

    localparam logic [CFG_IDX_W-1:0] CFG_LANDING_SPEED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_UNWIND        = CFG_IDX_W'(2);

    localparam int MS_PER_S = 1000;

    // shared divider: dividend magnitude, divisor, two quotient bits per cycle
    localparam int DIV_W     = 40;
    localparam int DEN_W     = 16;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SPEED_DIV,
        ST_SPEED_WAIT,
        ST_RING_SUB,
        ST_RING_ADD,
        ST_AVG_DIV,
        ST_AVG_WAIT,
        ST_OUTPUT
    } t_state;

endpackage

// ===== src/landing_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landing_detector
// Debounced landing detection from a ring average of vertical speed.
// ----------------------------------------------------------------------------
// Input channel: one item per telemetry tick (altitude, tick length, phase
// time), taken when i_in_valid is high and o_in_stall is low. Each item gives
// exactly one result item on the output channel, held in an output register
// until taken (o_out_valid high, i_out_stall low).
// Each item runs through one shared iterative divider twice: speed =
// |diff*1000| / tick, then average = |ring sum| / RING_DEPTH, each at two
// quotient bits a cycle. After acceptance an item passes the multiply, the
// speed division, the ring update, the average division and the result stage
// before it reaches the output register; o_in_stall stays high over that span,
// so a new item is taken only once the last one is through.
// A stalled receiver only holds the block in its last stage; a new item is
// accepted while a finished result still sits in the output register.
// Reset (i_rst_n low, synchronous) clears the speed ring, its running sum,
// the previous altitude, the run counter and loads the register defaults.
// Config writes (o_cfg_ready always high) are meant for idle periods.
// ----------------------------------------------------------------------------
module landing_detector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [lndet_pkg::ALT_W-1:0]   i_altitude_mm,
    input  logic [lndet_pkg::TICK_W-1:0]         i_tick_ms,
    input  logic [lndet_pkg::PHASE_W-1:0]        i_phase_time_ms,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_unwind_active,
    output logic signed [lndet_pkg::SPEED_W-1:0] o_average_speed_mm_s,
    output logic                                 o_landed,
    // config write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lndet_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lndet_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lndet_pkg::*;

    t_state r_state, n_state;

    // config registers
    logic [LAND_W-1:0]   r_land_speed;
    logic [DEB_W-1:0]    r_deb_needed;
    logic [UNWIND_W-1:0] r_unwind_ms;

    // persistent state
    logic signed [ALT_W-1:0]   r_prev_alt;
    logic signed [SPEED_W-1:0] r_ring [RING_DEPTH];
    logic [RING_IDX_W-1:0]     r_pos;
    logic signed [SUM_W-1:0]   r_sum;
    logic [DEB_W-1:0]          r_run;

    // per-item working registers
    logic signed [ALT_W:0]     r_diff;
    logic [TICK_W-1:0]         r_tick;
    logic                      r_unwind;
    logic                      r_neg;
    logic [DIV_W-1:0]          r_num;
    logic signed [SPEED_W-1:0] r_speed;
    logic signed [SPEED_W-1:0] r_avg;
    logic                      r_landed;

    // output registers
    logic                      r_out_valid;
    logic                      r_out_unwind;
    logic signed [SPEED_W-1:0] r_out_avg;
    logic                      r_out_landed;

    // control
    logic     accept;
    logic     out_load;
    logic     in_stall;
    t_div_req div_req;
    logic     div_done;
    logic [DIV_W-1:0] div_quo;

    // datapath helpers
    logic [ALT_W:0]          diff_mag;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [SPEED_W-1:0] speed_sat;
    logic [SPEED_W-1:0]      avg_mag;
    logic                    qualifies;
    logic [DEB_W-1:0]        run_next;
    logic [DEB_W-1:0]        need;

    lndet_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (i_in_valid) n_state = ST_MUL;
            ST_MUL:        n_state = ST_SPEED_DIV;
            ST_SPEED_DIV:  n_state = ST_SPEED_WAIT;
            ST_SPEED_WAIT: if (div_done) n_state = ST_RING_SUB;
            ST_RING_SUB:   n_state = ST_RING_ADD;
            ST_RING_ADD:   n_state = ST_AVG_DIV;
            ST_AVG_DIV:    n_state = ST_AVG_WAIT;
            ST_AVG_WAIT:   if (div_done) n_state = ST_OUTPUT;
            ST_OUTPUT:     if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        in_stall         = 1'b1;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_num;
        div_req.divisor  = r_tick;
        unique case (r_state)
            ST_IDLE:      in_stall = 1'b0;
            ST_SPEED_DIV: div_req.start = 1'b1;
            ST_AVG_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(sum_mag);
                div_req.divisor  = DEN_W'(RING_DEPTH);
            end
            ST_OUTPUT:    out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    assign accept = i_in_valid && !in_stall;

    // ---------------- datapath helpers ----------------
    always_comb begin
        diff_mag = r_diff[ALT_W] ? (ALT_W+1)'(-r_diff) : (ALT_W+1)'(r_diff);
        sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

        // saturate the speed quotient to signed 32 bits
        if (r_neg) begin
            if ((div_quo[DIV_W-1:SPEED_W] != '0) ||
                (div_quo[SPEED_W-1] && (div_quo[SPEED_W-2:0] != '0))) begin
                speed_sat = {1'b1, {(SPEED_W-1){1'b0}}};
            end else begin
                speed_sat = -$signed(div_quo[SPEED_W-1:0]);
            end
        end else begin
            if (div_quo[DIV_W-1:SPEED_W-1] != '0) begin
                speed_sat = {1'b0, {(SPEED_W-1){1'b1}}};
            end else begin
                speed_sat = $signed(div_quo[SPEED_W-1:0]);
            end
        end

        // the average magnitude never exceeds 2^31
        avg_mag   = div_quo[SPEED_W-1:0];
        qualifies = avg_mag < SPEED_W'(r_land_speed);
        if (!qualifies) begin
            run_next = '0;
        end else if (r_run == '1) begin
            run_next = r_run;
        end else begin
            run_next = r_run + 1'b1;
        end
        need = (r_deb_needed == '0) ? DEB_W'(1) : r_deb_needed;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_land_speed <= LAND_RST;
            r_deb_needed <= DEB_RST;
            r_unwind_ms  <= UNWIND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LANDING_SPEED: r_land_speed <= i_cfg_data[LAND_W-1:0];
                CFG_DEBOUNCE:      r_deb_needed <= i_cfg_data[DEB_W-1:0];
                CFG_UNWIND:        r_unwind_ms  <= i_cfg_data[UNWIND_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_alt <= '0;
            r_pos      <= '0;
            r_sum      <= '0;
            r_run      <= '0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_prev_alt <= i_altitude_mm;
            end
            if (r_state == ST_RING_SUB) begin
                r_sum         <= r_sum - SUM_W'(r_ring[r_pos]);
                r_ring[r_pos] <= r_speed;
            end
            if (r_state == ST_RING_ADD) begin
                r_sum <= r_sum + SUM_W'(r_speed);
                if (r_pos == RING_IDX_W'(RING_DEPTH - 1)) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if ((r_state == ST_AVG_WAIT) && div_done) begin
                r_run <= run_next;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_diff   <= (ALT_W+1)'(i_altitude_mm) - (ALT_W+1)'(r_prev_alt);
            r_tick   <= (i_tick_ms == '0) ? TICK_W'(1) : i_tick_ms;
            r_unwind <= i_phase_time_ms < PHASE_W'(r_unwind_ms);
        end
        if (r_state == ST_MUL) begin
            r_neg <= r_diff[ALT_W];
            r_num <= DIV_W'(diff_mag * 10'(MS_PER_S));
        end
        if ((r_state == ST_SPEED_WAIT) && div_done) begin
            r_speed <= speed_sat;
        end
        if ((r_state == ST_AVG_WAIT) && div_done) begin
            r_avg    <= r_sum[SUM_W-1] ? -$signed(avg_mag) : $signed(avg_mag);
            r_landed <= qualifies && (run_next >= need);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_unwind <= r_unwind;
            r_out_avg    <= r_avg;
            r_out_landed <= r_landed;
        end
    end

    assign o_in_stall           = in_stall;
    assign o_out_valid          = r_out_valid;
    assign o_unwind_active      = r_out_unwind;
    assign o_average_speed_mm_s = r_out_avg;
    assign o_landed             = r_out_landed;
    assign o_cfg_ready          = 1'b1;

endmodule

// ===== src/lndet_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lndet_div
// Iterative unsigned divider, restoring, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module lndet_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lndet_pkg::t_div_req     i_req,
    output logic                    o_done,
    output logic [lndet_pkg::DIV_W-1:0] o_quotient
);
    import lndet_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;

    logic [DIV_W-1:0] n_quo_a, n_quo;
    logic [DEN_W-1:0] n_rem_a, n_rem;

    // one restoring step: dividend bits shift out of quo as quotient bits shift in
    function automatic logic [DEN_W+DIV_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [DIV_W-1:0] quo,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] rem_o;
        logic             qbit;
        trial = {rem, quo[DIV_W-1]};
        if (trial >= {1'b0, den}) begin
            rem_o = DEN_W'(trial - {1'b0, den});
            qbit  = 1'b1;
        end else begin
            rem_o = trial[DEN_W-1:0];
            qbit  = 1'b0;
        end
        return {rem_o, quo[DIV_W-2:0], qbit};
    endfunction

    always_comb begin
        {n_rem_a, n_quo_a} = div_step(r_rem, r_quo, r_den);
        {n_rem, n_quo}     = div_step(n_rem_a, n_quo_a, r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== verif/landing_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landing_detector_tb
// Self-checking bench for the landing detector. A queue-fed driver sends
// telemetry ticks, and a local predictor models the speed ring, the running
// average and the debounce counter. A monitor checks every result item field
// by field. Both channels idle in random bursts. Register settings change
// between phases, once all results have drained.
// ----------------------------------------------------------------------------
module landing_detector_tb;
    import lndet_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 100;
    localparam int RUN_MAX     = 255;
    localparam int ALT_HI      = 2**(ALT_W-1) - 1;
    localparam int ALT_LO      = -(2**(ALT_W-1));
    localparam longint SPEED_HI = 64'sd2147483647;
    localparam longint SPEED_LO = -64'sd2147483648;
    // index 3 has no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    typedef struct {
        logic signed [ALT_W-1:0] alt;
        logic [TICK_W-1:0]       tick;
        logic [PHASE_W-1:0]      phase;
    } t_tick_item;

    typedef struct {
        logic                      unwind;
        logic signed [SPEED_W-1:0] avg;
        logic                      landed;
    } t_verdict;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [ALT_W-1:0]     i_altitude_mm = '0;
    logic [TICK_W-1:0]           i_tick_ms = '0;
    logic [PHASE_W-1:0]          i_phase_time_ms = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic                        o_unwind_active;
    logic signed [SPEED_W-1:0]   o_average_speed_mm_s;
    logic                        o_landed;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;

    // predictor state
    logic [LAND_W-1:0]   mdl_land_speed;
    logic [DEB_W-1:0]    mdl_debounce;
    logic [UNWIND_W-1:0] mdl_unwind;
    int                  last_alt;
    int                  speed_hist[RING_DEPTH];
    int                  hist_pos;
    int                  qual_run;

    t_tick_item pending_ticks[$];
    t_verdict   awaited_verdicts[$];

    int  ticks_driven = 0;
    int  ticks_accepted = 0;
    int  results_seen = 0;
    int  landed_seen = 0;
    int  sat_speeds = 0;
    int  settings_cnt = 0;
    int  err_cnt = 0;
    int  cycle_cnt = 0;
    int  send_gap_left = 0;
    int  recv_gap_left = 0;
    bit  idle_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    landing_detector i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_altitude_mm        (i_altitude_mm),
        .i_tick_ms            (i_tick_ms),
        .i_phase_time_ms      (i_phase_time_ms),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_unwind_active      (o_unwind_active),
        .o_average_speed_mm_s (o_average_speed_mm_s),
        .o_landed             (o_landed),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    function automatic longint clamp_speed(input longint v);
        if (v > SPEED_HI) return SPEED_HI;
        if (v < SPEED_LO) return SPEED_LO;
        return v;
    endfunction

    function automatic t_verdict predict_verdict(input t_tick_item t);
        longint   alt, diff, spd, sum, avg, mag;
        longint   divisor;
        int       need;
        bit       qual;
        t_verdict v;
        alt = longint'($signed(t.alt));
        divisor = (t.tick == '0) ? 64'sd1 : longint'(t.tick);
        diff = alt - longint'(last_alt);
        spd = (diff * MS_PER_S) / divisor;
        last_alt = int'(alt);
        if (hist_pos >= RING_DEPTH) hist_pos = 0;
        if (clamp_speed(spd) != spd) sat_speeds++;
        speed_hist[hist_pos] = int'(clamp_speed(spd));
        sum = 0;
        for (int i = 0; i < RING_DEPTH; i++) sum += longint'(speed_hist[i]);
        avg = clamp_speed(sum / RING_DEPTH);
        hist_pos++;
        if (hist_pos >= RING_DEPTH) hist_pos = 0;
        mag = (avg < 0) ? -avg : avg;
        qual = mag < longint'(mdl_land_speed);
        if (!qual) begin
            qual_run = 0;
        end else if (qual_run < RUN_MAX) begin
            qual_run++;
        end
        need = (mdl_debounce == '0) ? 1 : int'(mdl_debounce);
        v.unwind = t.phase < mdl_unwind;
        v.avg    = avg[SPEED_W-1:0];
        v.landed = qual && (qual_run >= need);
        return v;
    endfunction

    // random burst gaps: ~0.3% chance to start one while idling is enabled
    function automatic bit roll_gap(inout int left);
        if (left > 0) begin
            left--;
            return 1'b1;
        end
        if (idle_on && $urandom_range(999) < 3) begin
            left = $urandom_range(55);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what);
        err_cnt++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic add_tick(input int alt, input int tk, input logic [PHASE_W-1:0] ph);
        t_tick_item t;
        t.alt   = alt[ALT_W-1:0];
        t.tick  = tk[TICK_W-1:0];
        t.phase = ph;
        pending_ticks.push_back(t);
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || ticks_accepted != ticks_driven ||
               awaited_verdicts.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // called at a falling edge; leaves valid high for a following write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LANDING_SPEED: mdl_land_speed = val[LAND_W-1:0];
            CFG_DEBOUNCE:      mdl_debounce   = val[DEB_W-1:0];
            CFG_UNWIND:        mdl_unwind     = val[UNWIND_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] land,
                                 input logic [CFG_DATA_W-1:0] deb,
                                 input logic [CFG_DATA_W-1:0] unw,
                                 input bit poke_spare);
        wait_drained();
        cfg_write(CFG_LANDING_SPEED, land);
        cfg_write(CFG_DEBOUNCE, deb);
        cfg_write(CFG_UNWIND, unw);
        if (poke_spare) cfg_write(CFG_SPARE, $urandom());
        i_cfg_valid <= 1'b0;
        settings_cnt++;
    endtask

    // descents onto the ground with jitter, plus the odd tick of pure noise
    task automatic queue_flight(input int n);
        int               alt, rate, tk, jit;
        logic [PHASE_W-1:0] ph;
        alt  = $urandom_range(30000);
        rate = $urandom_range(500, 9000);
        ph   = $urandom_range(2500);
        for (int k = 0; k < n; k++) begin
            tk = $urandom_range(5, 120);
            ph += tk;
            if ($urandom_range(24) == 0) begin
                add_tick($urandom(), $urandom(), $urandom());
            end else begin
                alt -= rate * tk / 1000;
                if (alt < 0) alt = 0;
                jit = $urandom_range(6) - 3;
                add_tick(alt + jit, tk, ph);
            end
            if ($urandom_range(59) == 0) begin
                alt  = $urandom_range(30000);
                rate = $urandom_range(500, 9000);
                ph   = $urandom_range(2500);
            end
        end
    endtask

    // sender: a new item goes out only once the previous one was taken
    always @(negedge i_clk) begin : tick_driver
        bit gap;
        gap = roll_gap(send_gap_left);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (ticks_driven == ticks_accepted) begin
            if (pending_ticks.size() != 0 && !gap) begin
                i_in_valid      <= 1'b1;
                i_altitude_mm   <= pending_ticks[0].alt;
                i_tick_ms       <= pending_ticks[0].tick;
                i_phase_time_ms <= pending_ticks[0].phase;
                ticks_driven++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : stall_driver
        i_out_stall <= roll_gap(recv_gap_left);
    end

    always @(posedge i_clk) begin : tick_accept
        t_tick_item t;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            t = pending_ticks.pop_front();
            awaited_verdicts.push_back(predict_verdict(t));
            ticks_accepted++;
        end
    end

    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_landed === 1'b1) landed_seen++;
            if (awaited_verdicts.size() == 0) begin
                flag_mismatch($sformatf("result %0d with nothing expected", results_seen));
            end else begin
                want = awaited_verdicts.pop_front();
                if (o_unwind_active !== want.unwind)
                    flag_mismatch($sformatf("result %0d unwind_active %b, want %b",
                                            results_seen, o_unwind_active, want.unwind));
                if (o_average_speed_mm_s !== want.avg)
                    flag_mismatch($sformatf("result %0d average %0d, want %0d",
                                            results_seen, o_average_speed_mm_s, want.avg));
                if (o_landed !== want.landed)
                    flag_mismatch($sformatf("result %0d landed %b, want %b",
                                            results_seen, o_landed, want.landed));
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk) cycle_cnt++;
        $display("Timed out after %0d cycles, %0d results pending",
                 cycle_cnt, awaited_verdicts.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] land, deb, unw;
        int                    r;
        mdl_land_speed = LAND_RST;
        mdl_debounce   = DEB_RST;
        mdl_unwind     = UNWIND_RST;
        last_alt = 0;
        hist_pos = 0;
        qual_run = 0;
        foreach (speed_hist[i]) speed_hist[i] = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: first tick against zero altitude, field extremes,
        // zero tick length, saturation both ways, unwind boundary
        add_tick(0, 10, 0);
        add_tick(ALT_HI, 0, 1999);
        add_tick(ALT_LO, 1, 2000);
        add_tick(ALT_LO, 65535, 32'hFFFF_FFFF);
        add_tick(0, 65535, 1);
        add_tick(-1000000, 1, 2001);
        add_tick(100000000, 1, 0);
        for (int k = 0; k < 11; k++) add_tick(100000000, 50, 100 * k);

        // wide values masked: debounce 0 acts as 1, widest windows
        load_settings(32'hFFFF_FFFF, 32'h0000_0100, 32'hFFFF_FFFF, 1'b1);
        for (int k = 0; k < 14; k++) add_tick(5 + k % 3, 20, 65530 + k);

        // nothing qualifies, unwind window closed
        load_settings(0, 1, 0, 1'b0);
        for (int k = 0; k < 6; k++) add_tick(5, 20, 0);

        // long quiet stretch on the ground: run counter must stop at 255
        load_settings(32'h0001_FFFF, 255, 2000, 1'b0);
        idle_on = 1'b0;
        for (int k = 0; k < 300; k++) add_tick(5, 20, 20 * k);
        wait_drained();
        idle_on = 1'b1;

        for (int p = 0; p < 8; p++) begin
            r = $urandom_range(9);
            land = (r == 0) ? 0 : (r == 1) ? 100000 : (r == 2) ? 32'h1FFFF
                                                               : $urandom_range(300, 6000);
            if ($urandom_range(3) == 0) land |= $urandom() << LAND_W;
            r = $urandom_range(9);
            deb = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 255 : $urandom_range(2, 40);
            r = $urandom_range(9);
            unw = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(500, 5000);
            load_settings(land, deb, unw, $urandom_range(3) == 0);
            idle_on = (p != 3);
            if (p == 5) begin
                // hold the sender until every result is back
                queue_flight(60);
                wait_drained();
                queue_flight(65);
            end else begin
                queue_flight(125);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d results from %0d ticks; %0d landed, %0d saturated speeds",
                 results_seen, ticks_accepted, landed_seen, sat_speeds);
        $display("Ran %0d register settings after the reset defaults", settings_cnt);
        if (err_cnt == 0 && awaited_verdicts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
